### rtl/resp_command_parser_assert.svh
// ----------------------------------------------------------------------------
// resp_command_parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RESP_COMMAND_PARSER_ASSERT_SVH
`define RESP_COMMAND_PARSER_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define RCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that forces an expectation in the next.
`define RCP_ASSERT_NEXT(lbl, cond, expect_next, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

### rtl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// Types and constants shared by the request parser modules.
// ----------------------------------------------------------------------------
package rcp_pkg;

  // Protocol characters.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  // Number of bytes skipped after bulk data.
  localparam logic [1:0] SKIP_INIT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MAX_ARG_COUNT   = 1'b0;
  localparam logic REG_MAX_BULK_LENGTH = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] MAX_ARG_COUNT_RST   = 16'hFFFF;
  localparam logic [29:0] MAX_BULK_LENGTH_RST = 30'h2000_0000;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_BOUNDARY,
    PH_COUNT,
    PH_DOLLAR,
    PH_LEN,
    PH_DATA,
    PH_SKIP,
    PH_INLINE
  } rcp_phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ARG_BYTE,
    KIND_EMPTY_ARG,
    KIND_END_CMD,
    KIND_ERROR
  } rcp_kind_t;

  // A request byte with its character classes.
  typedef struct packed {
    logic [7:0] data;
    logic       is_ws;
    logic       is_dig;
    logic       is_cr;
    logic       is_lf;
    logic       is_star;
    logic       is_dollar;
    logic       is_plus;
    logic       is_minus;
    logic       is_lower;
  } rcp_class_t;

  // One result word.
  typedef struct packed {
    rcp_kind_t   kind;
    logic [7:0]  arg_byte;
    logic [15:0] arg_number;
    logic        first_of_arg;
    logic        last_of_arg;
  } rcp_result_t;

  // Configuration register values.
  typedef struct packed {
    logic [15:0] max_arg_count;
    logic [29:0] max_bulk_length;
  } rcp_cfg_t;

endpackage

### rtl/rcp_fifo.sv
// ----------------------------------------------------------------------------
// rcp_fifo
// Small flop-based first-in first-out queue used between parser stages.
// ----------------------------------------------------------------------------
`include "resp_command_parser_assert.svh"

module rcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_ok;
  logic             pop_ok;

  // Status and handshake qualification.
  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign push_ok  = push & ~full;
  assign pop_ok   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // The fill count stays in range and tracks the handshakes.
  `RCP_ASSERT(a_count_range, count_r <= CNT_FULL, "fifo count above depth")
  `RCP_ASSERT_NEXT(a_push_fills, push_ok && !pop_ok, !empty, "fifo empty after a word went in")
  `RCP_ASSERT_NEXT(a_pop_frees, pop_ok && !push_ok, !full, "fifo full after a word went out")
  `RCP_ASSERT_NEXT(a_both_hold, push_ok && pop_ok, $stable(count_r), "fifo count moved on push and pop")

endmodule

### rtl/rcp_front.sv
// ----------------------------------------------------------------------------
// rcp_front
// Classifies each incoming request byte for the parser back end.
// ----------------------------------------------------------------------------
module rcp_front (
  input  logic [7:0]          in_byte,
  output rcp_pkg::rcp_class_t cls
);

  // Character classes of the byte.
  always_comb begin
    cls.data      = in_byte;
    cls.is_ws     = (in_byte inside {[rcp_pkg::CH_TAB:rcp_pkg::CH_CR], rcp_pkg::CH_SPACE});
    cls.is_dig    = (in_byte inside {[rcp_pkg::CH_ZERO:rcp_pkg::CH_NINE]});
    cls.is_cr     = (in_byte == rcp_pkg::CH_CR);
    cls.is_lf     = (in_byte == rcp_pkg::CH_LF);
    cls.is_star   = (in_byte == rcp_pkg::CH_STAR);
    cls.is_dollar = (in_byte == rcp_pkg::CH_DOLLAR);
    cls.is_plus   = (in_byte == rcp_pkg::CH_PLUS);
    cls.is_minus  = (in_byte == rcp_pkg::CH_MINUS);
    cls.is_lower  = (in_byte inside {[rcp_pkg::CH_LOW_A:rcp_pkg::CH_LOW_Z]});
  end

endmodule

### rtl/rcp_back.sv
// ----------------------------------------------------------------------------
// rcp_back
// Parser state machine: turns classified bytes into argument result words.
// ----------------------------------------------------------------------------
`include "resp_command_parser_assert.svh"

module rcp_back #(
  parameter int ARG_INDEX_BITS = 16,
  parameter int LENGTH_BITS    = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcp_pkg::rcp_cfg_t    cfg,
  input  logic                 cls_valid,
  input  rcp_pkg::rcp_class_t  cls,
  output logic                 cls_take,
  input  logic                 res_full,
  output logic                 res_push,
  output rcp_pkg::rcp_result_t res
);

  localparam int CW = (LENGTH_BITS > 30) ? LENGTH_BITS : 30;
  localparam int MW = LENGTH_BITS + 4;
  localparam logic [ARG_INDEX_BITS-1:0] ARG_CAP  = '1;
  localparam logic [LENGTH_BITS-1:0]    LEN_MASK = '1;

  rcp_pkg::rcp_phase_t       phase_r, phase_nxt;
  logic [ARG_INDEX_BITS-1:0] args_left_r, args_left_nxt;
  logic [LENGTH_BITS-1:0]    bytes_left_r, bytes_left_nxt;
  logic [LENGTH_BITS-1:0]    accum_r, accum_nxt;
  logic                      neg_r, neg_nxt;
  logic                      has_dig_r, has_dig_nxt;
  logic                      done_r, done_nxt;
  logic                      sign_r, sign_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [ARG_INDEX_BITS-1:0] cur_r, cur_nxt;
  logic [7:0]                held_byte_r, held_byte_nxt;
  logic                      held_valid_r, held_valid_nxt;
  logic                      held_first_r, held_first_nxt;
  logic                      saw_cr_r, saw_cr_nxt;
  logic [1:0]                skip_r, skip_nxt;
  logic                      err_r, err_nxt;

  logic                      active;
  logic                      line_end;
  logic                      accum_zero;
  logic                      count_bad;
  logic                      count_drop;
  logic                      count_err;
  logic                      len_err;
  logic                      data_last;
  logic [1:0]                skip_dec;
  logic [ARG_INDEX_BITS-1:0] args_dec;
  logic [ARG_INDEX_BITS-1:0] cur_eff;
  logic                      hv_eff;
  logic                      hf_eff;
  logic                      scr_eff;
  logic                      in_eol;
  logic                      tok_err;
  logic [7:0]                up_byte;
  logic                      done_pre;
  logic [MW-1:0]             prod;
  logic                      prod_ovf;
  logic                      feed_go;
  logic                      inline_go;
  logic                      err_go;

  // A byte is taken whenever one waits and the result queue has room.
  assign cls_take = cls_valid & ~res_full;
  assign active   = cls_take & ~err_r;

  // Number line conditions.
  assign line_end   = saw_cr_r & cls.is_lf;
  assign accum_zero = (accum_r == '0);
  assign count_bad  = ~has_dig_r | ovf_r;
  assign count_drop = neg_r | accum_zero;
  assign count_err  = count_bad |
                      (~count_drop & ((CW'(accum_r) > CW'(cfg.max_arg_count)) |
                                      (CW'(accum_r) > CW'(ARG_CAP))));
  assign len_err    = count_bad | (neg_r & ~accum_zero) |
                      (CW'(accum_r) > CW'(cfg.max_bulk_length));

  // Digit accumulation: times ten plus the new digit, saturating.
  assign done_pre = done_r | (saw_cr_r & (has_dig_r | sign_r));
  assign prod     = (MW'(accum_r) << 3) + (MW'(accum_r) << 1) + MW'(cls.data[3:0]);
  assign prod_ovf = |prod[MW-1:LENGTH_BITS];

  // Bulk data and trailer counters.
  assign data_last = (bytes_left_r <= LENGTH_BITS'(1));
  assign skip_dec  = (skip_r != '0) ? skip_r - 2'd1 : skip_r;
  assign args_dec  = (args_left_r != '0) ? args_left_r - ARG_INDEX_BITS'(1) : args_left_r;

  // Inline view: a new line starts from a clean argument state.
  always_comb begin
    if (phase_r == rcp_pkg::PH_BOUNDARY) begin
      cur_eff = '0;
      hv_eff  = 1'b0;
      hf_eff  = 1'b0;
      scr_eff = 1'b0;
    end else begin
      cur_eff = cur_r;
      hv_eff  = held_valid_r;
      hf_eff  = held_first_r;
      scr_eff = saw_cr_r;
    end
  end

  assign in_eol  = scr_eff & cls.is_lf;
  assign tok_err = (CW'(cur_eff) >= CW'(cfg.max_arg_count)) | (cur_eff == ARG_CAP);
  assign up_byte = ((cur_eff == '0) && cls.is_lower) ? (cls.data & rcp_pkg::CASE_MASK)
                                                      : cls.data;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (active) begin
      case (phase_r)
        rcp_pkg::PH_BOUNDARY: begin
          phase_nxt = cls.is_star ? rcp_pkg::PH_COUNT : rcp_pkg::PH_INLINE;
        end
        rcp_pkg::PH_COUNT: begin
          if (line_end && !count_err) begin
            phase_nxt = count_drop ? rcp_pkg::PH_BOUNDARY : rcp_pkg::PH_DOLLAR;
          end
        end
        rcp_pkg::PH_DOLLAR: begin
          if (cls.is_dollar) begin
            phase_nxt = rcp_pkg::PH_LEN;
          end
        end
        rcp_pkg::PH_LEN: begin
          if (line_end && !len_err) begin
            phase_nxt = accum_zero ? rcp_pkg::PH_SKIP : rcp_pkg::PH_DATA;
          end
        end
        rcp_pkg::PH_DATA: begin
          if (data_last) begin
            phase_nxt = rcp_pkg::PH_SKIP;
          end
        end
        rcp_pkg::PH_SKIP: begin
          if (skip_dec == '0) begin
            phase_nxt = (args_dec == '0) ? rcp_pkg::PH_BOUNDARY : rcp_pkg::PH_DOLLAR;
          end
        end
        rcp_pkg::PH_INLINE: begin
          if (in_eol) begin
            phase_nxt = rcp_pkg::PH_BOUNDARY;
          end
        end
        default: begin
          phase_nxt = rcp_pkg::PH_BOUNDARY;
        end
      endcase
    end
  end

  // Datapath updates and result words.
  always_comb begin
    args_left_nxt  = args_left_r;
    bytes_left_nxt = bytes_left_r;
    accum_nxt      = accum_r;
    neg_nxt        = neg_r;
    has_dig_nxt    = has_dig_r;
    done_nxt       = done_r;
    sign_nxt       = sign_r;
    ovf_nxt        = ovf_r;
    cur_nxt        = cur_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r;
    saw_cr_nxt     = saw_cr_r;
    skip_nxt       = skip_r;
    err_nxt        = err_r;
    feed_go        = 1'b0;
    inline_go      = 1'b0;
    err_go         = 1'b0;
    res_push       = 1'b0;
    res.kind         = rcp_pkg::KIND_ARG_BYTE;
    res.arg_byte     = '0;
    res.arg_number   = '0;
    res.first_of_arg = 1'b0;
    res.last_of_arg  = 1'b0;

    if (active) begin
      case (phase_r)
        rcp_pkg::PH_BOUNDARY: begin
          if (cls.is_star) begin
            accum_nxt   = '0;
            neg_nxt     = 1'b0;
            has_dig_nxt = 1'b0;
            done_nxt    = 1'b0;
            sign_nxt    = 1'b0;
            ovf_nxt     = 1'b0;
            saw_cr_nxt  = 1'b0;
          end else begin
            inline_go = 1'b1;
          end
        end
        rcp_pkg::PH_COUNT: begin
          if (line_end) begin
            saw_cr_nxt = 1'b0;
            if (count_err) begin
              err_go = 1'b1;
            end else if (!count_drop) begin
              args_left_nxt = ARG_INDEX_BITS'(accum_r);
              cur_nxt       = '0;
            end
          end else begin
            feed_go = 1'b1;
          end
        end
        rcp_pkg::PH_DOLLAR: begin
          if (!cls.is_dollar) begin
            err_go = 1'b1;
          end else begin
            accum_nxt   = '0;
            neg_nxt     = 1'b0;
            has_dig_nxt = 1'b0;
            done_nxt    = 1'b0;
            sign_nxt    = 1'b0;
            ovf_nxt     = 1'b0;
            saw_cr_nxt  = 1'b0;
          end
        end
        rcp_pkg::PH_LEN: begin
          if (line_end) begin
            saw_cr_nxt = 1'b0;
            if (len_err) begin
              err_go = 1'b1;
            end else if (accum_zero) begin
              res_push         = 1'b1;
              res.kind         = rcp_pkg::KIND_EMPTY_ARG;
              res.arg_number   = 16'(cur_r);
              res.first_of_arg = 1'b1;
              res.last_of_arg  = 1'b1;
              skip_nxt         = rcp_pkg::SKIP_INIT;
            end else begin
              bytes_left_nxt = accum_r;
              held_first_nxt = 1'b1;
            end
          end else begin
            feed_go = 1'b1;
          end
        end
        rcp_pkg::PH_DATA: begin
          res_push         = 1'b1;
          res.kind         = rcp_pkg::KIND_ARG_BYTE;
          res.arg_byte     = up_byte;
          res.arg_number   = 16'(cur_r);
          res.first_of_arg = held_first_r;
          res.last_of_arg  = data_last;
          held_first_nxt   = 1'b0;
          if (data_last) begin
            bytes_left_nxt = '0;
            skip_nxt       = rcp_pkg::SKIP_INIT;
          end else begin
            bytes_left_nxt = bytes_left_r - LENGTH_BITS'(1);
          end
        end
        rcp_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            args_left_nxt = args_dec;
            if (args_dec == '0) begin
              res_push = 1'b1;
              res.kind = rcp_pkg::KIND_END_CMD;
              cur_nxt  = '0;
            end else begin
              cur_nxt = cur_r + ARG_INDEX_BITS'(1);
            end
          end
        end
        rcp_pkg::PH_INLINE: begin
          inline_go = 1'b1;
        end
        default: begin
        end
      endcase

      // Number line byte: a lone CR counts as whitespace.
      if (feed_go) begin
        saw_cr_nxt = cls.is_cr;
        done_nxt   = done_pre;
        if (!cls.is_cr && !done_pre) begin
          if (!has_dig_r) begin
            if (!sign_r && cls.is_ws) begin
              done_nxt = done_pre;
            end else if (!sign_r && (cls.is_plus || cls.is_minus)) begin
              sign_nxt = 1'b1;
              neg_nxt  = cls.is_minus;
            end else if (cls.is_dig) begin
              has_dig_nxt = 1'b1;
              accum_nxt   = LENGTH_BITS'(cls.data[3:0]);
            end else begin
              done_nxt = 1'b1;
            end
          end else if (cls.is_dig) begin
            accum_nxt = prod_ovf ? LEN_MASK : prod[LENGTH_BITS-1:0];
            if (prod_ovf) begin
              ovf_nxt = 1'b1;
            end
          end else begin
            done_nxt = 1'b1;
          end
        end
      end

      // Inline line byte: split on whitespace, one byte held back.
      if (inline_go) begin
        cur_nxt        = cur_eff;
        held_valid_nxt = hv_eff;
        held_first_nxt = hf_eff;
        saw_cr_nxt     = 1'b0;
        if (in_eol) begin
          if (cur_eff != '0) begin
            res_push = 1'b1;
            res.kind = rcp_pkg::KIND_END_CMD;
          end
          cur_nxt = '0;
        end else if (cls.is_ws) begin
          if (hv_eff) begin
            res_push         = 1'b1;
            res.kind         = rcp_pkg::KIND_ARG_BYTE;
            res.arg_byte     = held_byte_r;
            res.arg_number   = 16'(cur_eff);
            res.first_of_arg = hf_eff;
            res.last_of_arg  = 1'b1;
            held_valid_nxt   = 1'b0;
            cur_nxt          = cur_eff + ARG_INDEX_BITS'(1);
          end
          saw_cr_nxt = cls.is_cr;
        end else if (hv_eff) begin
          res_push         = 1'b1;
          res.kind         = rcp_pkg::KIND_ARG_BYTE;
          res.arg_byte     = held_byte_r;
          res.arg_number   = 16'(cur_eff);
          res.first_of_arg = hf_eff;
          res.last_of_arg  = 1'b0;
          held_first_nxt   = 1'b0;
          held_byte_nxt    = up_byte;
        end else if (tok_err) begin
          err_go = 1'b1;
        end else begin
          held_byte_nxt  = up_byte;
          held_valid_nxt = 1'b1;
          held_first_nxt = 1'b1;
        end
      end

      // Protocol error: one error word, then the parser goes quiet.
      if (err_go) begin
        err_nxt          = 1'b1;
        res_push         = 1'b1;
        res.kind         = rcp_pkg::KIND_ERROR;
        res.arg_byte     = '0;
        res.arg_number   = '0;
        res.first_of_arg = 1'b0;
        res.last_of_arg  = 1'b0;
      end
    end
  end

  // Held byte carries no reset.
  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rcp_pkg::PH_BOUNDARY;
      args_left_r  <= '0;
      bytes_left_r <= '0;
      accum_r      <= '0;
      neg_r        <= 1'b0;
      has_dig_r    <= 1'b0;
      done_r       <= 1'b0;
      sign_r       <= 1'b0;
      ovf_r        <= 1'b0;
      cur_r        <= '0;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
      saw_cr_r     <= 1'b0;
      skip_r       <= '0;
      err_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      args_left_r  <= args_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      accum_r      <= accum_nxt;
      neg_r        <= neg_nxt;
      has_dig_r    <= has_dig_nxt;
      done_r       <= done_nxt;
      sign_r       <= sign_nxt;
      ovf_r        <= ovf_nxt;
      cur_r        <= cur_nxt;
      held_valid_r <= held_valid_nxt;
      held_first_r <= held_first_nxt;
      saw_cr_r     <= saw_cr_nxt;
      skip_r       <= skip_nxt;
      err_r        <= err_nxt;
    end
  end

  // Once latched, an error stays and no further word is produced.
  `RCP_ASSERT_NEXT(a_err_sticky, err_r, err_r, "error latch cleared without reset")
  `RCP_ASSERT(a_err_silent, !(err_r && res_push), "word produced after a latched error")
  // A word only goes out together with a byte taken from the input queue.
  `RCP_ASSERT(a_push_on_take, !res_push || cls_take, "word produced without a byte taken")

endmodule

### rtl/resp_command_parser.sv
// Path: a pushed byte is held in the classified-byte queue, parsed by the back end as
// it is taken from that queue, and its result word is written into the result queue,
// whose head drives the out ports. A full result queue stalls the parser.
// Throughput: one byte per cycle while the result queue has room, set by the parser.
// Reset: synchronous, active low; the parser returns to a command boundary, the
// queues empty and the limits return to 65535 arguments and 2^29 bulk bytes.
// ----------------------------------------------------------------------------
// resp_command_parser
// Streaming request parser: classifies bytes in front, parses them in the
// back end, and queues result words for the consumer.
// ----------------------------------------------------------------------------
module resp_command_parser #(
  parameter int ARG_INDEX_BITS = 16,
  parameter int LENGTH_BITS    = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request byte input.
  input  logic        push,
  input  logic [7:0]  in_byte,
  output logic        full,
  // Result word output.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_arg_byte,
  output logic [15:0] out_arg_number,
  output logic        out_first_of_arg,
  output logic        out_last_of_arg,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [29:0] cfg_data
);

  localparam int CLS_W = $bits(rcp_pkg::rcp_class_t);
  localparam int RES_W = $bits(rcp_pkg::rcp_result_t);

  rcp_pkg::rcp_cfg_t    cfg_r;
  rcp_pkg::rcp_class_t  cls_in;
  rcp_pkg::rcp_class_t  cls_out;
  rcp_pkg::rcp_result_t res_in;
  rcp_pkg::rcp_result_t res_out;
  logic [CLS_W-1:0]     cls_q_data;
  logic [RES_W-1:0]     res_q_data;
  logic                 cls_empty;
  logic                 cls_take;
  logic                 res_full;
  logic                 res_push;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_arg_count   <= rcp_pkg::MAX_ARG_COUNT_RST;
      cfg_r.max_bulk_length <= rcp_pkg::MAX_BULK_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rcp_pkg::REG_MAX_ARG_COUNT) begin
        cfg_r.max_arg_count <= cfg_data[15:0];
      end else begin
        cfg_r.max_bulk_length <= cfg_data;
      end
    end
  end

  // Front end: byte classification.
  rcp_front u_front (
    .in_byte (in_byte),
    .cls     (cls_in)
  );

  // Queue of classified bytes between front and back.
  rcp_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (4)
  ) u_cls_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls_in),
    .full      (full),
    .pop       (cls_take),
    .pop_data  (cls_q_data),
    .empty     (cls_empty)
  );

  assign cls_out = rcp_pkg::rcp_class_t'(cls_q_data);

  // Back end: parser state machine.
  rcp_back #(
    .ARG_INDEX_BITS (ARG_INDEX_BITS),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cls_valid (~cls_empty),
    .cls       (cls_out),
    .cls_take  (cls_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue toward the consumer.
  rcp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_q_data),
    .empty     (empty)
  );

  assign res_out          = rcp_pkg::rcp_result_t'(res_q_data);
  assign out_kind         = res_out.kind;
  assign out_arg_byte     = res_out.arg_byte;
  assign out_arg_number   = res_out.arg_number;
  assign out_first_of_arg = res_out.first_of_arg;
  assign out_last_of_arg  = res_out.last_of_arg;

endmodule
